[rtl/core/stable_quadratic_root_solver_macros.svh]
// Assertion macros for the stable quadratic root solver.
// Used by modules that check their own pipeline; expects aclk and aresetn in scope.
`ifndef STABLE_QUADRATIC_ROOT_SOLVER_MACROS_SVH
`define STABLE_QUADRATIC_ROOT_SOLVER_MACROS_SVH
`ifndef SYNTHESIS
// checked property, disabled while in reset
`define SQRS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// checked property, also live during reset
`define SQRS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define SQRS_ASSERT(lbl, prop, msg)
`define SQRS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[rtl/core/sqrs_pkg.sv]
// Shared types and defaults for the stable quadratic root solver.
// No dependencies; imported by every module of the block.
package sqrs_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;

    // coefficient signs and discriminant status, carried through the square root
    typedef struct packed {
        logic eq;
        logic dneg;
        logic a_neg;
        logic b_neg;
        logic c_neg;
        logic c_zero;
    } coef_flags_t;

    // root status, carried through the dividers
    typedef struct packed {
        logic eq;
        logic real_ok;
        logic lok;
        logic rep;
        logic neg_s;
        logic neg_l;
    } root_flags_t;

endpackage

[rtl/core/sqrs_sqrt.sv]
// Pipelined integer square root, one result bit per register stage.
// Depends on sqrs_pkg for the side-band flag type.
module sqrs_sqrt #(
    parameter int RAD_W = 66,
    parameter int MAG_W = 96
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [RAD_W-1:0]          in_rad,
    input  sqrs_pkg::coef_flags_t     in_flags,
    input  logic [MAG_W-1:0]          in_mags,
    output logic                      out_valid,
    output logic [RAD_W/2-1:0]        out_root,
    output sqrs_pkg::coef_flags_t     out_flags,
    output logic [MAG_W-1:0]          out_mags
);
    import sqrs_pkg::*;

    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 2;

    logic              vld_reg   [ROOT_W];
    logic [RAD_W-1:0]  rad_reg   [ROOT_W];
    logic [REM_W-1:0]  rem_reg   [ROOT_W];
    logic [ROOT_W-1:0] root_reg  [ROOT_W];
    coef_flags_t       flags_reg [ROOT_W];
    logic [MAG_W-1:0]  mags_reg  [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic              valid_in;
        logic [RAD_W-1:0]  rad_in;
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        coef_flags_t       flags_in;
        logic [MAG_W-1:0]  mags_in;
        logic [REM_W-1:0]  rem_sh;
        logic [REM_W-1:0]  trial;
        logic              ge;

        // pick the stage source
        if (k == 0) begin : g_first
            assign valid_in = in_valid;
            assign rad_in   = in_rad;
            assign rem_in   = '0;
            assign root_in  = '0;
            assign flags_in = in_flags;
            assign mags_in  = in_mags;
        end else begin : g_next
            assign valid_in = vld_reg[k-1];
            assign rad_in   = rad_reg[k-1];
            assign rem_in   = rem_reg[k-1];
            assign root_in  = root_reg[k-1];
            assign flags_in = flags_reg[k-1];
            assign mags_in  = mags_reg[k-1];
        end

        // bring down two radicand bits and try the next root digit
        assign rem_sh = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
        assign trial  = {root_in, 2'b01};
        assign ge     = (rem_sh >= trial);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= valid_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rad_reg[k]   <= rad_in << 2;
                rem_reg[k]   <= ge ? (rem_sh - trial) : rem_sh;
                root_reg[k]  <= {root_in[ROOT_W-2:0], ge};
                flags_reg[k] <= flags_in;
                mags_reg[k]  <= mags_in;
            end
        end
    end

    assign out_valid = vld_reg[ROOT_W-1];
    assign out_root  = root_reg[ROOT_W-1];
    assign out_flags = flags_reg[ROOT_W-1];
    assign out_mags  = mags_reg[ROOT_W-1];

endmodule

[rtl/core/sqrs_div.sv]
// Two-lane pipelined restoring divider, one quotient bit per register stage.
// Depends on sqrs_pkg for the side-band flag type.
module sqrs_div #(
    parameter int NUM_W = 50,
    parameter int DEN_W = 34
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [NUM_W-1:0]      num_s,
    input  logic [DEN_W-1:0]      den_s,
    input  logic [NUM_W-1:0]      num_l,
    input  logic [DEN_W-1:0]      den_l,
    input  sqrs_pkg::root_flags_t in_flags,
    output logic                  out_valid,
    output logic [NUM_W-1:0]      quo_s,
    output logic [NUM_W-1:0]      quo_l,
    output sqrs_pkg::root_flags_t out_flags
);
    import sqrs_pkg::*;

    logic             vld_reg   [NUM_W];
    root_flags_t      flags_reg [NUM_W];
    logic [NUM_W-1:0] acc_reg   [2][NUM_W];
    logic [DEN_W-1:0] rem_reg   [2][NUM_W];
    logic [DEN_W-1:0] den_reg   [2][NUM_W];
    logic [NUM_W-1:0] num_in    [2];
    logic [DEN_W-1:0] den_in    [2];

    assign num_in[0] = num_s;
    assign num_in[1] = num_l;
    assign den_in[0] = den_s;
    assign den_in[1] = den_l;

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic        valid_in;
        root_flags_t flags_in;

        if (k == 0) begin : g_first
            assign valid_in = in_valid;
            assign flags_in = in_flags;
        end else begin : g_next
            assign valid_in = vld_reg[k-1];
            assign flags_in = flags_reg[k-1];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= valid_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                flags_reg[k] <= flags_in;
            end
        end

        for (genvar j = 0; j < 2; j++) begin : g_lane
            logic [NUM_W-1:0] acc_in;
            logic [DEN_W-1:0] rem_in;
            logic [DEN_W-1:0] dv_in;
            logic [DEN_W:0]   rem_sh;
            logic [DEN_W:0]   diff;
            logic             ge;

            if (k == 0) begin : g_first
                assign acc_in = num_in[j];
                assign rem_in = '0;
                assign dv_in  = den_in[j];
            end else begin : g_next
                assign acc_in = acc_reg[j][k-1];
                assign rem_in = rem_reg[j][k-1];
                assign dv_in  = den_reg[j][k-1];
            end

            // shift in the next dividend bit and subtract where it fits
            assign rem_sh = {rem_in, acc_in[NUM_W-1]};
            assign diff   = rem_sh - {1'b0, dv_in};
            assign ge     = (rem_sh >= {1'b0, dv_in});

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[j][k] <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
                    acc_reg[j][k] <= {acc_in[NUM_W-2:0], ge};
                    den_reg[j][k] <= dv_in;
                end
            end
        end
    end

    assign out_valid = vld_reg[NUM_W-1];
    assign out_flags = flags_reg[NUM_W-1];
    assign quo_s     = acc_reg[0][NUM_W-1];
    assign quo_l     = acc_reg[1][NUM_W-1];

endmodule

[rtl/core/sqrs_post.sv]
// Saturation, root selection, sorting and output register of the solver.
// Depends on sqrs_pkg for the root flag type.
module sqrs_post #(
    parameter int WORD_BITS = 32,
    parameter int NUM_W     = 50
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [NUM_W-1:0]            quo_s,
    input  logic [NUM_W-1:0]            quo_l,
    input  sqrs_pkg::root_flags_t       in_flags,
    output logic                        m_valid,
    output logic                        m_equation_ok,
    output logic signed [WORD_BITS-1:0] m_root_small,
    output logic                        m_root_small_ok,
    output logic signed [WORD_BITS-1:0] m_root_large,
    output logic                        m_root_large_ok,
    output logic [1:0]                  m_unique_count,
    output logic signed [WORD_BITS-1:0] m_unique_low,
    output logic signed [WORD_BITS-1:0] m_unique_high,
    output logic signed [WORD_BITS-1:0] m_least_positive,
    output logic                        m_least_positive_ok,
    output logic                        m_saturated
);
    import sqrs_pkg::*;

    localparam int W = WORD_BITS;
    localparam logic [NUM_W-1:0] POS_LIM = (NUM_W'(1) << (W - 1)) - NUM_W'(1);
    localparam logic [NUM_W-1:0] NEG_LIM = NUM_W'(1) << (W - 1);

    // clip flag over the signed, saturated root
    function automatic logic [W:0] sat_root(input logic [NUM_W-1:0] q, input logic neg);
        logic [NUM_W-1:0] lim;
        logic             clip;
        logic [W-1:0]     mag;
        lim  = neg ? NEG_LIM : POS_LIM;
        clip = (q > lim);
        mag  = clip ? lim[W-1:0] : q[W-1:0];
        return {clip, neg ? (~mag + W'(1)) : mag};
    endfunction

    logic               p1_vld_reg;
    logic signed [W-1:0] rs_reg, rl_reg;
    logic               clip_s_reg, clip_l_reg;
    root_flags_t        p1_flags_reg;
    logic [W:0]         sat_s, sat_l;

    assign sat_s = sat_root(quo_s, in_flags.neg_s);
    assign sat_l = sat_root(quo_l, in_flags.neg_l);

    // stage one: saturate both quotients
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_vld_reg <= 1'b0;
        end else if (en) begin
            p1_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rs_reg       <= sat_s[W-1:0];
            rl_reg       <= sat_l[W-1:0];
            clip_s_reg   <= sat_s[W];
            clip_l_reg   <= sat_l[W];
            p1_flags_reg <= in_flags;
        end
    end

    // stage two: select, sort, average and pick the least positive root
    logic                sok, lok, pos_s, pos_l, s_lt_l;
    logic signed [W:0]   sum;
    logic signed [W-1:0] rs_v, rl_v, ulo, uhi, lp;
    logic [1:0]          cnt;

    assign sok    = p1_flags_reg.eq && p1_flags_reg.real_ok;
    assign lok    = sok && p1_flags_reg.lok;
    assign s_lt_l = (rs_reg < rl_reg);
    assign sum    = {rs_reg[W-1], rs_reg} + {rl_reg[W-1], rl_reg};
    assign pos_s  = sok && (rs_reg > 0);
    assign pos_l  = lok && (rl_reg > 0);

    always_comb begin
        rs_v = sok ? rs_reg : '0;
        rl_v = lok ? rl_reg : '0;
        cnt  = 2'd0;
        ulo  = '0;
        uhi  = '0;
        if (sok) begin
            if (p1_flags_reg.rep) begin
                cnt = 2'd1;
                ulo = lok ? sum[W:1] : rs_reg;
            end else if (lok) begin
                cnt = 2'd2;
                ulo = s_lt_l ? rs_reg : rl_reg;
                uhi = s_lt_l ? rl_reg : rs_reg;
            end else begin
                cnt = 2'd1;
                ulo = rs_reg;
            end
        end
        if (pos_s && pos_l) begin
            lp = s_lt_l ? rs_reg : rl_reg;
        end else if (pos_s) begin
            lp = rs_reg;
        end else if (pos_l) begin
            lp = rl_reg;
        end else begin
            lp = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (en) begin
            m_valid <= p1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_equation_ok       <= p1_flags_reg.eq;
            m_root_small        <= rs_v;
            m_root_small_ok     <= sok;
            m_root_large        <= rl_v;
            m_root_large_ok     <= lok;
            m_unique_count      <= cnt;
            m_unique_low        <= ulo;
            m_unique_high       <= uhi;
            m_least_positive    <= lp;
            m_least_positive_ok <= pos_s || pos_l;
            m_saturated         <= (sok && clip_s_reg) || (lok && clip_l_reg);
        end
    end

endmodule

[rtl/core/stable_quadratic_root_solver.sv]
// Stable quadratic root solver: coefficient products, discriminant, square root,
// divider lanes and output stage. Depends on sqrs_pkg, sqrs_sqrt, sqrs_div, sqrs_post.
//
// Usage: one beat on the s_ channel carries coefficients a, b and c of
// a*x^2 + b*x + c in signed fixed point (WORD_BITS bits, FRAC_BITS fraction).
// One beat on the m_ channel returns the two formula roots with valid bits,
// the sorted distinct roots, the least positive root and a saturation flag.
// The cfg_ channel writes the repeated-root tolerance; write it only while idle.
// The pipeline holds a products stage and a discriminant stage, WORD_BITS+1
// square-root digit stages, a set-up stage, WORD_BITS+FRAC_BITS+2 quotient-bit
// stages and the saturation and output stages. Throughput is one beat per cycle
// unless m_ready holds the pipeline; every stage advances together.
// Reset clears all valid bits and the tolerance (to zero); nothing else needs it.
// When the receiver holds m_ready low with a beat waiting, the whole pipeline
// holds and s_ready drops; no beat is lost or repeated.
`include "stable_quadratic_root_solver_macros.svh"
module stable_quadratic_root_solver #(
    parameter int WORD_BITS = sqrs_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = sqrs_pkg::FRAC_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [WORD_BITS-2:0]        cfg_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [WORD_BITS-1:0] s_coef_a,
    input  logic signed [WORD_BITS-1:0] s_coef_b,
    input  logic signed [WORD_BITS-1:0] s_coef_c,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_equation_ok,
    output logic signed [WORD_BITS-1:0] m_root_small,
    output logic                        m_root_small_ok,
    output logic signed [WORD_BITS-1:0] m_root_large,
    output logic                        m_root_large_ok,
    output logic [1:0]                  m_unique_count,
    output logic signed [WORD_BITS-1:0] m_unique_low,
    output logic signed [WORD_BITS-1:0] m_unique_high,
    output logic signed [WORD_BITS-1:0] m_least_positive,
    output logic                        m_least_positive_ok,
    output logic                        m_saturated
);
    import sqrs_pkg::*;

    localparam int W      = WORD_BITS;
    localparam int RAD_W  = 2 * W + 2;
    localparam int ROOT_W = W + 1;
    localparam int DEN_W  = W + 2;
    localparam int NUM_W  = W + FRAC_BITS + 2;
    localparam int MAG_W  = 3 * W;

    logic pipe_en;
    assign pipe_en   = !m_valid || m_ready;
    assign s_ready   = pipe_en;
    assign cfg_ready = 1'b1;

    // tolerance register
    logic [W-2:0] tol_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= '0;
        end else if (cfg_valid) begin
            tol_reg <= cfg_data;
        end
    end

    // stage one: magnitudes and the two products
    logic [W-1:0]   mag_a, mag_b, mag_c;
    logic           s1_vld_reg;
    logic [2*W-1:0] bb_reg, ac_reg;
    logic [W-1:0]   s1_mag_a_reg, s1_mag_b_reg, s1_mag_c_reg;
    coef_flags_t    s1_flags_reg;

    assign mag_a = s_coef_a[W-1] ? W'(~s_coef_a + W'(1)) : W'(s_coef_a);
    assign mag_b = s_coef_b[W-1] ? W'(~s_coef_b + W'(1)) : W'(s_coef_b);
    assign mag_c = s_coef_c[W-1] ? W'(~s_coef_c + W'(1)) : W'(s_coef_c);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
        end else if (pipe_en) begin
            s1_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            bb_reg              <= (2*W)'(mag_b) * (2*W)'(mag_b);
            ac_reg              <= (2*W)'(mag_a) * (2*W)'(mag_c);
            s1_mag_a_reg        <= mag_a;
            s1_mag_b_reg        <= mag_b;
            s1_mag_c_reg        <= mag_c;
            s1_flags_reg.eq     <= (s_coef_a != '0);
            s1_flags_reg.dneg   <= 1'b0;
            s1_flags_reg.a_neg  <= s_coef_a[W-1];
            s1_flags_reg.b_neg  <= s_coef_b[W-1];
            s1_flags_reg.c_neg  <= s_coef_c[W-1];
            s1_flags_reg.c_zero <= (s_coef_c == '0);
        end
    end

    // stage two: discriminant numerator b^2 - 4ac
    logic [RAD_W-1:0] ac4, bbx;
    logic             acpos;
    logic             s2_vld_reg;
    logic [RAD_W-1:0] rad_reg;
    logic [MAG_W-1:0] s2_mags_reg;
    coef_flags_t      s2_flags_next;
    coef_flags_t      s2_flags_reg;

    assign ac4   = {ac_reg, 2'b00};
    assign bbx   = {2'b00, bb_reg};
    assign acpos = !(s1_flags_reg.a_neg ^ s1_flags_reg.c_neg) && !s1_flags_reg.c_zero;

    // mark a negative discriminant
    always_comb begin
        s2_flags_next      = s1_flags_reg;
        s2_flags_next.dneg = acpos && (ac4 > bbx);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_vld_reg <= 1'b0;
        end else if (pipe_en) begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            rad_reg      <= acpos ? (bbx - ac4) : (bbx + ac4);
            s2_mags_reg  <= {s1_mag_a_reg, s1_mag_b_reg, s1_mag_c_reg};
            s2_flags_reg <= s2_flags_next;
        end
    end

    // square root of the discriminant
    logic              sq_vld;
    logic [ROOT_W-1:0] sq_root;
    coef_flags_t       sq_flags;
    logic [MAG_W-1:0]  sq_mags;

    sqrs_sqrt #(
        .RAD_W (RAD_W),
        .MAG_W (MAG_W)
    ) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (s2_vld_reg),
        .in_rad    (rad_reg),
        .in_flags  (s2_flags_reg),
        .in_mags   (s2_mags_reg),
        .out_valid (sq_vld),
        .out_root  (sq_root),
        .out_flags (sq_flags),
        .out_mags  (sq_mags)
    );

    // set-up stage: pick numerator and divisor for each formula branch
    logic [W-1:0]     q_mag_a, q_mag_b, q_mag_c;
    logic [DEN_W-1:0] tsum, a2;
    logic [NUM_W-1:0] num_t, num_c;
    logic             prep_vld_reg;
    logic [NUM_W-1:0] num_s_reg, num_l_reg;
    logic [DEN_W-1:0] den_s_reg, den_l_reg;
    root_flags_t      prep_flags_reg;

    assign {q_mag_a, q_mag_b, q_mag_c} = sq_mags;
    assign tsum  = {1'b0, sq_root} + {2'b00, q_mag_b};
    assign a2    = {1'b0, q_mag_a, 1'b0};
    assign num_t = {tsum, {FRAC_BITS{1'b0}}};
    assign num_c = {1'b0, q_mag_c, {(FRAC_BITS + 1){1'b0}}};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prep_vld_reg <= 1'b0;
        end else if (pipe_en) begin
            prep_vld_reg <= sq_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            num_s_reg              <= sq_flags.b_neg ? num_c : num_t;
            den_s_reg              <= sq_flags.b_neg ? tsum  : a2;
            num_l_reg              <= sq_flags.b_neg ? num_t : num_c;
            den_l_reg              <= sq_flags.b_neg ? a2    : tsum;
            prep_flags_reg.eq      <= sq_flags.eq;
            prep_flags_reg.real_ok <= !sq_flags.dneg;
            prep_flags_reg.lok     <= sq_flags.b_neg || (tsum != '0);
            prep_flags_reg.rep     <= (sq_root <= ROOT_W'(tol_reg));
            prep_flags_reg.neg_s   <= sq_flags.b_neg ? sq_flags.c_neg : !sq_flags.a_neg;
            prep_flags_reg.neg_l   <= sq_flags.b_neg ? sq_flags.a_neg
                                                     : (!sq_flags.c_neg && !sq_flags.c_zero);
        end
    end

    // both root quotients
    logic             dv_vld;
    logic [NUM_W-1:0] quo_s, quo_l;
    root_flags_t      dv_flags;

    sqrs_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (prep_vld_reg),
        .num_s     (num_s_reg),
        .den_s     (den_s_reg),
        .num_l     (num_l_reg),
        .den_l     (den_l_reg),
        .in_flags  (prep_flags_reg),
        .out_valid (dv_vld),
        .quo_s     (quo_s),
        .quo_l     (quo_l),
        .out_flags (dv_flags)
    );

    sqrs_post #(
        .WORD_BITS (W),
        .NUM_W     (NUM_W)
    ) u_post (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .en                  (pipe_en),
        .in_valid            (dv_vld),
        .quo_s               (quo_s),
        .quo_l               (quo_l),
        .in_flags            (dv_flags),
        .m_valid             (m_valid),
        .m_equation_ok       (m_equation_ok),
        .m_root_small        (m_root_small),
        .m_root_small_ok     (m_root_small_ok),
        .m_root_large        (m_root_large),
        .m_root_large_ok     (m_root_large_ok),
        .m_unique_count      (m_unique_count),
        .m_unique_low        (m_unique_low),
        .m_unique_high       (m_unique_high),
        .m_least_positive    (m_least_positive),
        .m_least_positive_ok (m_least_positive_ok),
        .m_saturated         (m_saturated)
    );

    // result consistency
    `SQRS_ASSERT(a_no_eq_no_root, m_valid && !m_equation_ok |-> !m_root_small_ok && !m_root_large_ok && m_unique_count == 2'd0, "root reported without equation")
    `SQRS_ASSERT(a_large_needs_small, m_valid && m_root_large_ok |-> m_root_small_ok, "large root valid without small root")
    `SQRS_ASSERT(a_count_range, m_valid |-> m_unique_count != 2'd3, "unique count out of range")
    `SQRS_ASSERT(a_sorted, m_valid && m_unique_count == 2'd2 |-> m_unique_low <= m_unique_high, "distinct roots not ascending")
    `SQRS_ASSERT(a_least_pos, m_valid && m_least_positive_ok |-> m_least_positive > 0, "least positive root not positive")
    `SQRS_ASSERT_ALWAYS(a_stall_holds_input, m_valid && !m_ready |-> !s_ready, "input taken while pipeline held")

endmodule

[sim/stable_quadratic_root_solver_tb.sv]
// Self-checking bench for the stable quadratic root solver: drives coefficient
// triples, predicts each result beat and compares it field by field.
// Depends on sqrs_pkg and the stable_quadratic_root_solver RTL.
`timescale 1ns / 100ps
module stable_quadratic_root_solver_tb;
    import sqrs_pkg::*;

    localparam int WB = WORD_BITS_DEF;
    localparam int FB = FRAC_BITS_DEF;
    localparam int LATENCY = 2 * WB + FB + 8;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [WB-2:0] TOL_MAX = '1;

    typedef struct {
        logic               eq_ok;
        logic signed [31:0] r_small;
        logic               r_small_ok;
        logic signed [31:0] r_large;
        logic               r_large_ok;
        logic [1:0]         cnt;
        logic signed [31:0] u_low;
        logic signed [31:0] u_high;
        logic signed [31:0] lpos;
        logic               lpos_ok;
        logic               sat;
    } roots_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [WB-2:0] cfg_data = '0;
    logic s_valid = 0;
    logic s_ready;
    logic signed [WB-1:0] s_coef_a = '0, s_coef_b = '0, s_coef_c = '0;
    logic m_valid;
    logic m_ready = 0;
    logic m_equation_ok, m_root_small_ok, m_root_large_ok, m_least_positive_ok;
    logic m_saturated;
    logic signed [WB-1:0] m_root_small, m_root_large, m_unique_low, m_unique_high;
    logic signed [WB-1:0] m_least_positive;
    logic [1:0] m_unique_count;

    logic [WB-2:0] tolerance = '0;
    roots_t pending_roots[$];
    int errors = 0;
    int idle_cycles = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_off = 0;

    stable_quadratic_root_solver dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_coef_a(s_coef_a), .s_coef_b(s_coef_b), .s_coef_c(s_coef_c),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_equation_ok(m_equation_ok),
        .m_root_small(m_root_small), .m_root_small_ok(m_root_small_ok),
        .m_root_large(m_root_large), .m_root_large_ok(m_root_large_ok),
        .m_unique_count(m_unique_count),
        .m_unique_low(m_unique_low), .m_unique_high(m_unique_high),
        .m_least_positive(m_least_positive),
        .m_least_positive_ok(m_least_positive_ok),
        .m_saturated(m_saturated)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // (mag << sh) / den truncated, signed by neg, clipped to the word range
    function automatic logic [32:0] clip_quotient(logic [63:0] mag, int sh,
                                                  logic [63:0] den, bit neg);
        logic [127:0] q;
        logic [127:0] lim;
        logic signed [31:0] r;
        q = (128'(mag) << sh) / 128'(den);
        lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
        if (q > lim) begin
            r = neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
            return {1'b1, r};
        end
        r = neg ? -q[31:0] : q[31:0];
        return {1'b0, r};
    endfunction

    function automatic logic [63:0] isqrt128(logic [127:0] n);
        logic [63:0] res;
        logic [63:0] cand;
        res = '0;
        for (int i = 63; i >= 0; i--) begin
            cand = res | (64'd1 << i);
            if (128'(cand) * 128'(cand) <= n) res = cand;
        end
        return res;
    endfunction

    function automatic roots_t solve_roots(logic signed [31:0] a, logic signed [31:0] b,
                                           logic signed [31:0] c);
        roots_t r;
        logic signed [129:0] disc;
        logic [63:0] d, t, ma, mb, mc;
        logic [32:0] q1, q2;
        logic signed [33:0] sum;
        r = '{default: '0};
        r.eq_ok = (a != 0);
        if (!r.eq_ok) return r;
        disc = 130'(b) * 130'(b) - 130'sd4 * 130'(a) * 130'(c);
        if (disc < 0) return r;
        d = isqrt128(disc[127:0]);
        ma = a < 0 ? 64'(-64'sd1 * a) : 64'(a);
        mb = b < 0 ? 64'(-64'sd1 * b) : 64'(b);
        mc = c < 0 ? 64'(-64'sd1 * c) : 64'(c);
        t = d + mb;
        q2 = '0;
        if (b < 0) begin
            q1 = clip_quotient(mc, FB + 1, t, c < 0);
            q2 = clip_quotient(t, FB, ma << 1, a < 0);
            r.r_large_ok = 1;
        end else begin
            q1 = clip_quotient(t, FB, ma << 1, a > 0);
            if (t != 0) begin
                q2 = clip_quotient(mc, FB + 1, t, c > 0);
                r.r_large_ok = 1;
            end
        end
        r.r_small_ok = 1;
        r.r_small = q1[31:0];
        r.r_large = r.r_large_ok ? q2[31:0] : '0;
        r.sat = q1[32] | (r.r_large_ok & q2[32]);
        if (d <= 64'(tolerance)) begin
            r.cnt = 1;
            if (r.r_large_ok) begin
                sum = 34'(r.r_small) + 34'(r.r_large);
                r.u_low = 32'(sum >>> 1);
            end else r.u_low = r.r_small;
        end else if (r.r_large_ok) begin
            r.cnt = 2;
            r.u_low = r.r_small < r.r_large ? r.r_small : r.r_large;
            r.u_high = r.r_small < r.r_large ? r.r_large : r.r_small;
        end else begin
            r.cnt = 1;
            r.u_low = r.r_small;
        end
        if (r.r_small > 0) begin
            r.lpos = r.r_small;
            r.lpos_ok = 1;
        end
        if (r.r_large_ok && r.r_large > 0 && (!r.lpos_ok || r.r_large < r.lpos)) begin
            r.lpos = r.r_large;
            r.lpos_ok = 1;
        end
        return r;
    endfunction

    // offer one beat; drop valid only while idling so beats can follow back to back
    task automatic send_triple(logic signed [31:0] a, logic signed [31:0] b,
                               logic signed [31:0] c);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 0;
            @(negedge aclk);
        end
        s_valid <= 1;
        s_coef_a <= a;
        s_coef_b <= b;
        s_coef_c <= c;
        do @(posedge aclk); while (!s_ready);
        pending_roots.push_back(solve_roots(a, b, c));
        @(negedge aclk);
    endtask

    task automatic drain;
        s_valid <= 0;
        while (pending_roots.size() != 0) @(negedge aclk);
        repeat (LATENCY + 4) @(negedge aclk);
    endtask

    task automatic write_tolerance(logic [WB-2:0] value);
        drain();
        cfg_valid <= 1;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        tolerance = value;
        @(negedge aclk);
        cfg_valid <= 0;
    endtask

    function automatic logic [31:0] rand_coef();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'($signed($urandom_range(16)) - 8) << 16;
            2: return 32'($signed($urandom_range(4000)) - 2000) << 8;
            3: return {{16{1'($urandom_range(1))}}, 16'($urandom)};
            4: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return 32'($signed($urandom_range(200000)) - 100000);
        endcase
    endfunction

    task automatic test_directed;
        logic signed [31:0] ext[6];
        ext = '{32'sh8000_0000, 32'sh7fff_ffff, 0, 1, -1, 32'sh0001_0000};
        send_triple(0, 32'sh0001_0000, 5);              // zero quadratic coefficient
        send_triple(32'sh10000, 0, 32'sh10000);         // negative discriminant
        send_triple(32'sh10000, 0, 0);                  // zero divisor in max formula
        send_triple(32'sh10000, -32'sh20000, 32'sh10000); // exact repeated root
        send_triple(32'sh10000, -32'sh30000, 32'sh20000); // roots 1 and 2
        send_triple(-32'sh10000, 32'sh30000, -32'sh20000);
        send_triple(1, 32'sh7fff_ffff, 1);              // saturating root
        send_triple(32'sh10000, 32'sh10000, -32'sh20000); // one positive root
        for (int i = 0; i < 6; i++)
            for (int j = 0; j < 3; j++)
                send_triple(ext[i], ext[(i + j) % 6], ext[(i + 2 * j + 1) % 6]);
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++) send_triple(rand_coef(), rand_coef(), rand_coef());
    endtask

    task automatic test_tolerance;
        write_tolerance(TOL_MAX);
        test_directed();
        test_random(60);
        write_tolerance((WB-1)'(32'h0001_0000));
        test_random(60);
        write_tolerance((WB-1)'($urandom));
        test_random(60);
        write_tolerance('0);
    endtask

    task automatic test_idling;
        send_idle_pct = 83;
        test_random(200);
        send_idle_pct = 0;
        recv_stall_pct = 83;
        test_random(200);
        send_idle_pct = 36;
        recv_stall_pct = 36;
        test_random(200);
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    task automatic test_backpressure;
        hold_off = 1;
        test_random(150);
        drain();
        test_random(100);
    endtask

    // receiver: random stalls, plus one long hold-off counted here
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_off) begin
                m_ready <= 0;
                repeat (300) @(negedge aclk);
                hold_off = 0;
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // check each result beat against the oldest prediction
    always @(posedge aclk) begin
        roots_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_roots.size() == 0) begin
                $display("%0t: result beat with none expected", $time);
                errors++;
            end else begin
                e = pending_roots.pop_front();
                if ({m_equation_ok, m_root_small, m_root_small_ok, m_root_large,
                     m_root_large_ok, m_unique_count, m_unique_low, m_unique_high,
                     m_least_positive, m_least_positive_ok, m_saturated} !==
                    {e.eq_ok, e.r_small, e.r_small_ok, e.r_large, e.r_large_ok, e.cnt,
                     e.u_low, e.u_high, e.lpos, e.lpos_ok, e.sat}) begin
                    $display("%0t: exp eq=%b rs=%h/%b rl=%h/%b n=%0d lo=%h hi=%h lp=%h/%b s=%b",
                             $time, e.eq_ok, e.r_small, e.r_small_ok, e.r_large,
                             e.r_large_ok, e.cnt, e.u_low, e.u_high, e.lpos, e.lpos_ok,
                             e.sat);
                    $display("%0t: got eq=%b rs=%h/%b rl=%h/%b n=%0d lo=%h hi=%h lp=%h/%b s=%b",
                             $time, m_equation_ok, m_root_small, m_root_small_ok,
                             m_root_large, m_root_large_ok, m_unique_count, m_unique_low,
                             m_unique_high, m_least_positive, m_least_positive_ok,
                             m_saturated);
                    errors++;
                end
            end
        end
    end

    // watchdog: count cycles without any accepted beat
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("stable_quadratic_root_solver: mismatch");
            $finish;
        end
    end

    initial begin
        repeat (4) @(negedge aclk);
        aresetn <= 1;
        test_directed();
        test_random(170);
        test_tolerance();
        test_idling();
        test_backpressure();
        drain();
        if (errors == 0 && pending_roots.size() == 0)
            $display("stable_quadratic_root_solver: match");
        else
            $display("stable_quadratic_root_solver: mismatch");
        $finish;
    end
endmodule

[sim.f]
+incdir+rtl/core
rtl/core/sqrs_pkg.sv
rtl/core/sqrs_sqrt.sv
rtl/core/sqrs_div.sv
rtl/core/sqrs_post.sv
rtl/core/stable_quadratic_root_solver.sv
sim/stable_quadratic_root_solver_tb.sv
